// ===== sv/hcpp_pkg.sv =====
// shared constants for the hard-core point placement block
`timescale 1ns / 1ps
package hcpp_pkg;

  localparam int CMD_W      = 2;
  localparam int FRAC_W     = 16;
  localparam int COORD_W    = 16;
  localparam int IDX_W      = 6;
  localparam int CNT_OUT_W  = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // command codes
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_OFFER = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_X  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_Y  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_Z  = 3'd4;

  // register reset values
  localparam logic [CNT_OUT_W-1:0]  TARGET_RST = 7'd64;
  localparam logic [CFG_DATA_W-1:0] RADIUS_RST = 16'd256;
  localparam logic [CFG_DATA_W-1:0] BOX_RST    = 16'd2560;

  // one half in Q0.16, also the rounding bias for the Q8.24 product
  localparam logic [FRAC_W:0] HALF_FRAC = 17'd32768;
  localparam logic [33:0]     ROUND_BIAS = 34'd32768;

endpackage

// ===== sv/hard_core_point_placement.sv =====
// hard-core point placement: rejection test against a point store in block ram
// clear, read, unused and unscanned offers go through the scale, round and finish states before the result beat
// an offer against a non-empty store also scans: the scan reads one stored point per cycle
// from the store memory's single read port, then a two-stage square pipeline drains
// throughput: one item at a time, next input beat taken once the result is registered
// reset: stored count 0, registers to their defaults, store contents undefined (no clear pass)
`timescale 1ns / 1ps
module hard_core_point_placement #(
  parameter int MAX_POINTS = 64,
  parameter int DIMS       = 3
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [hcpp_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [hcpp_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [hcpp_pkg::CMD_W-1:0]         command_i,
  input  logic [hcpp_pkg::FRAC_W-1:0]        frac_x_i,
  input  logic [hcpp_pkg::FRAC_W-1:0]        frac_y_i,
  input  logic [hcpp_pkg::FRAC_W-1:0]        frac_z_i,
  input  logic [hcpp_pkg::IDX_W-1:0]         read_index_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               accepted_o,
  output logic [hcpp_pkg::CNT_OUT_W-1:0]     placed_count_o,
  output logic                               done_res_o,
  output logic signed [hcpp_pkg::COORD_W-1:0] pos_x_o,
  output logic signed [hcpp_pkg::COORD_W-1:0] pos_y_o,
  output logic signed [hcpp_pkg::COORD_W-1:0] pos_z_o
);
  import hcpp_pkg::*;

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int EW = (CW > CNT_OUT_W) ? CW : CNT_OUT_W;
  localparam int MW = DIMS * COORD_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCALE = 3'd1;
  localparam logic [2:0] S_ROUND = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  // configuration
  logic [CNT_OUT_W-1:0]  target_q;
  logic [CFG_DATA_W-1:0] radius_q;
  logic [CFG_DATA_W-1:0] box_q [3];

  // control
  logic [2:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] issue_q, issue_d;
  logic          v1_q, v1_d, v2_q, v2_d;
  logic          hit_q, hit_d;
  logic          acc_q, acc_d;
  logic          out_valid_q, out_valid_d;

  // item payload
  logic [CMD_W-1:0]          cmd_q;
  logic [IDX_W-1:0]          rd_index_q;
  logic [FRAC_W-1:0]         frac_q [DIMS];
  logic signed [33:0]        prod_q [DIMS];
  logic [31:0]               r2_q;
  logic signed [COORD_W-1:0] pos_q [DIMS];
  logic [31:0]               sq_q [DIMS];

  // result registers
  logic                      acc_out_q;
  logic [CNT_OUT_W-1:0]      placed_q;
  logic                      done_q;
  logic signed [COORD_W-1:0] pos_out_q [3];

  // point store
  logic [MW-1:0] mem_q [MAX_POINTS];
  logic [MW-1:0] mem_rd_q;
  logic [AW-1:0] rd_addr;
  logic          mem_we;
  logic [MW-1:0] mem_wdata;

  logic [FRAC_W-1:0] frac_in [3];
  logic [EW-1:0]     eff_target;
  logic              room;
  logic              idx_valid;
  logic [33:0]       dist_sum;
  logic              load_out;
  logic [CW-1:0]     new_count;

  assign frac_in[0] = frac_x_i;
  assign frac_in[1] = frac_y_i;
  assign frac_in[2] = frac_z_i;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);

  assign eff_target = (EW'(target_q) > EW'(MAX_POINTS)) ? EW'(MAX_POINTS) : EW'(target_q);
  assign room       = EW'(count_q) < eff_target;
  assign idx_valid  = (EW'(rd_index_q) < EW'(count_q)) && (EW'(rd_index_q) < EW'(MAX_POINTS));
  assign rd_addr    = (state_q == S_SCAN) ? issue_q[AW-1:0] : AW'(rd_index_q);
  assign load_out   = (state_q == S_FIN) && (!out_valid_q || out_ready_i);

  always_comb begin
    dist_sum = '0;
    for (int k = 0; k < DIMS; k++) begin
      dist_sum = dist_sum + {2'b00, sq_q[k]};
    end
  end

  always_comb begin
    for (int k = 0; k < DIMS; k++) begin
      mem_wdata[k*COORD_W +: COORD_W] = pos_q[k];
    end
  end

  always_comb begin
    if (cmd_q == CMD_CLEAR) begin
      new_count = '0;
    end else if (acc_q) begin
      new_count = CW'(count_q + 1'b1);
    end else begin
      new_count = count_q;
    end
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    issue_d     = issue_q;
    v1_d        = 1'b0;
    v2_d        = 1'b0;
    hit_d       = hit_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mem_we      = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_SCALE;
        end
      end
      S_SCALE: begin
        state_d = S_ROUND;
      end
      S_ROUND: begin
        acc_d = 1'b0;
        if (cmd_q == CMD_OFFER && room) begin
          if (count_q == '0) begin
            acc_d   = 1'b1;
            state_d = S_FIN;
          end else begin
            issue_d = '0;
            hit_d   = 1'b0;
            state_d = S_SCAN;
          end
        end else begin
          state_d = S_FIN;
        end
      end
      S_SCAN: begin
        if (issue_q < count_q) begin
          issue_d = CW'(issue_q + 1'b1);
          v1_d    = 1'b1;
        end
        v2_d = v1_q;
        if (v2_q && (dist_sum < {2'b00, r2_q})) begin
          hit_d = 1'b1;
        end
        // all reads issued and the square pipeline empty
        if (issue_q == count_q && !v1_q && !v2_q) begin
          acc_d   = !hit_q;
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          count_d     = new_count;
          mem_we      = acc_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      issue_q     <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      hit_q       <= 1'b0;
      acc_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      issue_q     <= issue_d;
      v1_q        <= v1_d;
      v2_q        <= v2_d;
      hit_q       <= hit_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= TARGET_RST;
      radius_q <= RADIUS_RST;
      box_q[0] <= BOX_RST;
      box_q[1] <= BOX_RST;
      box_q[2] <= BOX_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_TARGET: target_q <= cfg_data_i[CNT_OUT_W-1:0];
        CFG_RADIUS: radius_q <= cfg_data_i;
        CFG_BOX_X:  box_q[0] <= cfg_data_i;
        CFG_BOX_Y:  box_q[1] <= cfg_data_i;
        CFG_BOX_Z:  box_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      cmd_q      <= command_i;
      rd_index_q <= read_index_i;
      for (int k = 0; k < DIMS; k++) begin
        frac_q[k] <= frac_in[k];
      end
    end
    if (state_q == S_SCALE) begin
      r2_q <= 32'(radius_q) * 32'(radius_q);
      // (u - half) * box, Q8.24
      for (int k = 0; k < DIMS; k++) begin
        prod_q[k] <= $signed({1'b0, frac_q[k]} - HALF_FRAC) * $signed({1'b0, box_q[k]});
      end
    end
    if (state_q == S_ROUND) begin
      for (int k = 0; k < DIMS; k++) begin
        if (cmd_q == CMD_OFFER) begin
          pos_q[k] <= COORD_W'((prod_q[k] + $signed(ROUND_BIAS)) >>> 16);
        end else if (cmd_q == CMD_READ && idx_valid) begin
          pos_q[k] <= mem_rd_q[k*COORD_W +: COORD_W];
        end else begin
          pos_q[k] <= '0;
        end
      end
    end
    for (int k = 0; k < DIMS; k++) begin
      logic signed [16:0] diff;
      logic signed [33:0] sq_full;
      diff = $signed({pos_q[k][COORD_W-1], pos_q[k]})
           - $signed({mem_rd_q[k*COORD_W+COORD_W-1], mem_rd_q[k*COORD_W +: COORD_W]});
      sq_full = diff * diff;
      sq_q[k] <= sq_full[31:0];
    end
    if (load_out) begin
      acc_out_q <= acc_q;
      placed_q  <= CNT_OUT_W'(new_count);
      done_q    <= EW'(new_count) >= eff_target;
      for (int k = 0; k < 3; k++) begin
        if (k < DIMS) begin
          pos_out_q[k] <= pos_q[k];
        end else begin
          pos_out_q[k] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[count_q[AW-1:0]] <= mem_wdata;
    end
    mem_rd_q <= mem_q[rd_addr];
  end

  assign out_valid_o    = out_valid_q;
  assign accepted_o     = acc_out_q;
  assign placed_count_o = placed_q;
  assign done_res_o     = done_q;
  assign pos_x_o        = pos_out_q[0];
  assign pos_y_o        = pos_out_q[1];
  assign pos_z_o        = pos_out_q[2];

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    EW'(count_q) <= EW'(MAX_POINTS))
    else $error("stored count beyond store depth");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (issue_q <= count_q))
    else $error("scan index ran past stored count");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FIN))
    else $error("result beat raised outside finish state");

  a_store_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> (count_q != '0))
    else $error("store write without count increment");

endmodule

// ===== sim/hard_core_point_placement_tb.sv =====
// self-checking testbench for hard_core_point_placement with a rejection-placement scoreboard
`timescale 1ns / 1ps
module hard_core_point_placement_tb;
  import hcpp_pkg::*;

  localparam int          STORE_DEPTH  = 64;
  localparam int          REPORT_LIMIT = 10;
  localparam int          TOTAL_ITEMS  = 1700;
  localparam int          HOLD_AT      = 300;
  localparam int          HOLD_CYCLES  = 500;
  localparam int          DRAIN_CYCLES = 8;
  localparam int unsigned LIMIT_NS     = 4_000_000;

  localparam logic [CMD_W-1:0]     CMD_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 3'd7;

  // default box of 10.0: these fractions land at 0, 1.0 and 255/256 on an axis
  localparam logic [FRAC_W-1:0] FRAC_MID       = 16'd32768;
  localparam logic [FRAC_W-1:0] FRAC_AT_RADIUS = 16'd39322;
  localparam logic [FRAC_W-1:0] FRAC_INSIDE    = 16'd39296;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [FRAC_W-1:0] frac_x;
    logic [FRAC_W-1:0] frac_y;
    logic [FRAC_W-1:0] frac_z;
    logic [IDX_W-1:0]  read_index;
  } place_req_t;

  typedef struct packed {
    logic                      accepted;
    logic [CNT_OUT_W-1:0]      placed_count;
    logic                      done_res;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
  } place_res_t;

  class placement_checker;
    logic [CNT_OUT_W-1:0]      cfg_target;
    logic [CFG_DATA_W-1:0]     cfg_radius;
    logic [CFG_DATA_W-1:0]     cfg_box [3];
    logic signed [COORD_W-1:0] point_store [STORE_DEPTH][3];
    int unsigned               n_placed;
    place_res_t                expected_q [$];
    int unsigned               errors;

    function new();
      cfg_target = TARGET_RST;
      cfg_radius = RADIUS_RST;
      foreach (cfg_box[k]) cfg_box[k] = BOX_RST;
      n_placed = 0;
      errors   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_TARGET: cfg_target = data[CNT_OUT_W-1:0];
        CFG_RADIUS: cfg_radius = data;
        CFG_BOX_X:  cfg_box[0] = data;
        CFG_BOX_Y:  cfg_box[1] = data;
        CFG_BOX_Z:  cfg_box[2] = data;
        default: ;
      endcase
    endfunction

    function int unsigned eff_target();
      return (cfg_target > STORE_DEPTH) ? STORE_DEPTH : cfg_target;
    endfunction

    // (u - 0.5) * box in Q8.24, rounded half up to Q8.8
    function logic signed [COORD_W-1:0] scale_coord(logic [FRAC_W-1:0] u,
                                                     logic [CFG_DATA_W-1:0] box);
      longint d;
      longint p;
      d = longint'(u) - 32768;
      p = (d * longint'(box) + 32768) >>> 16;
      return p[COORD_W-1:0];
    endfunction

    function bit too_close(logic signed [COORD_W-1:0] c [3], int idx);
      longint sum;
      longint diff;
      sum = 0;
      for (int k = 0; k < 3; k++) begin
        diff = longint'(c[k]) - longint'(point_store[idx][k]);
        sum += diff * diff;
      end
      return sum < longint'(cfg_radius) * longint'(cfg_radius);
    endfunction

    function void note_request(place_req_t req);
      place_res_t                res;
      logic signed [COORD_W-1:0] cand [3];
      logic [FRAC_W-1:0]         frac [3];
      bit                        clear_of_all;
      res  = '0;
      frac = '{req.frac_x, req.frac_y, req.frac_z};
      case (req.command)
        CMD_CLEAR: n_placed = 0;
        CMD_OFFER: begin
          for (int k = 0; k < 3; k++) cand[k] = scale_coord(frac[k], cfg_box[k]);
          // once the target is met the candidate is only scaled, never tested
          if (n_placed < eff_target()) begin
            clear_of_all = 1'b1;
            for (int i = 0; i < n_placed; i++) begin
              if (too_close(cand, i)) begin
                clear_of_all = 1'b0;
                break;
              end
            end
            if (clear_of_all) begin
              for (int k = 0; k < 3; k++) point_store[n_placed][k] = cand[k];
              n_placed++;
              res.accepted = 1'b1;
            end
          end
          res.pos_x = cand[0];
          res.pos_y = cand[1];
          res.pos_z = cand[2];
        end
        CMD_READ: begin
          if (req.read_index < n_placed) begin
            res.pos_x = point_store[req.read_index][0];
            res.pos_y = point_store[req.read_index][1];
            res.pos_z = point_store[req.read_index][2];
          end
        end
        default: ;
      endcase
      res.placed_count = n_placed[CNT_OUT_W-1:0];
      res.done_res     = (n_placed >= eff_target());
      expected_q = {expected_q, res};
    endfunction

    function void check_result(place_res_t got);
      place_res_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("unexpected result beat: acc=%0d cnt=%0d done=%0d pos=(%0d,%0d,%0d)",
                   got.accepted, got.placed_count, got.done_res,
                   got.pos_x, got.pos_y, got.pos_z);
        return;
      end
      want = expected_q.pop_front();
      if (got.accepted !== want.accepted || got.placed_count !== want.placed_count ||
          got.done_res !== want.done_res || got.pos_x !== want.pos_x ||
          got.pos_y !== want.pos_y || got.pos_z !== want.pos_z) begin
        errors++;
        if (errors <= REPORT_LIMIT) begin
          $display("mismatch exp: acc=%0d cnt=%0d done=%0d pos=(%0d,%0d,%0d)",
                   want.accepted, want.placed_count, want.done_res,
                   want.pos_x, want.pos_y, want.pos_z);
          $display("         got: acc=%0d cnt=%0d done=%0d pos=(%0d,%0d,%0d)",
                   got.accepted, got.placed_count, got.done_res,
                   got.pos_x, got.pos_y, got.pos_z);
        end
      end
    endfunction
  endclass

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic [CFG_IDX_W-1:0]      cfg_index_i;
  logic [CFG_DATA_W-1:0]     cfg_data_i;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic [CMD_W-1:0]          command_i;
  logic [FRAC_W-1:0]         frac_x_i;
  logic [FRAC_W-1:0]         frac_y_i;
  logic [FRAC_W-1:0]         frac_z_i;
  logic [IDX_W-1:0]          read_index_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic                      accepted_o;
  logic [CNT_OUT_W-1:0]      placed_count_o;
  logic                      done_res_o;
  logic signed [COORD_W-1:0] pos_x_o;
  logic signed [COORD_W-1:0] pos_y_o;
  logic signed [COORD_W-1:0] pos_z_o;

  placement_checker chk;
  int unsigned      items_sent;
  int unsigned      results_seen;
  int unsigned      next_gap;
  bit               sender_fast;
  bit               receiver_fast;

  hard_core_point_placement u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .frac_x_i       (frac_x_i),
    .frac_y_i       (frac_y_i),
    .frac_z_i       (frac_z_i),
    .read_index_i   (read_index_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .accepted_o     (accepted_o),
    .placed_count_o (placed_count_o),
    .done_res_o     (done_res_o),
    .pos_x_o        (pos_x_o),
    .pos_y_o        (pos_y_o),
    .pos_z_o        (pos_z_o)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  function automatic place_req_t mk_req(logic [CMD_W-1:0] cmd, logic [FRAC_W-1:0] fx,
                                        logic [FRAC_W-1:0] fy, logic [FRAC_W-1:0] fz,
                                        logic [IDX_W-1:0] idx);
    place_req_t r;
    r.command    = cmd;
    r.frac_x     = fx;
    r.frac_y     = fy;
    r.frac_z     = fz;
    r.read_index = idx;
    return r;
  endfunction

  // valid stays high across back-to-back beats; dropped only before a gap or a pause
  task automatic send_item(input place_req_t req, input bit pause_after);
    repeat (next_gap) @(posedge clk_i);
    in_valid_i   <= 1'b1;
    command_i    <= req.command;
    frac_x_i     <= req.frac_x;
    frac_y_i     <= req.frac_y;
    frac_z_i     <= req.frac_z;
    read_index_i <= req.read_index;
    do @(posedge clk_i); while (!in_ready_o);
    chk.note_request(req);
    if (req.command != CMD_UNUSED) items_sent++;
    next_gap = sender_fast ? 0 : $urandom_range(0, 7);
    if (next_gap != 0 || pause_after) in_valid_i <= 1'b0;
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    chk.write_reg(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_idle();
    while (chk.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin : result_sink
    int unsigned stall;
    place_res_t  got;
    out_ready_i  = 1'b0;
    results_seen = 0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = receiver_fast ? 0 : $urandom_range(0, 7);
      // one long hold-off so the block backs up into its input
      if (results_seen == HOLD_AT) stall = HOLD_CYCLES;
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      got.accepted     = accepted_o;
      got.placed_count = placed_count_o;
      got.done_res     = done_res_o;
      got.pos_x        = pos_x_o;
      got.pos_y        = pos_y_o;
      got.pos_z        = pos_z_o;
      chk.check_result(got);
      results_seen++;
    end
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    logic [FRAC_W-1:0]     rnd_frac;
    logic [3*FRAC_W-1:0]   recent [$];
    logic [3*FRAC_W-1:0]   base;
    logic [CFG_IDX_W-1:0]  box_reg [3];
    logic [CFG_DATA_W-1:0] val;
    logic [CMD_W-1:0]      cmd;
    logic [IDX_W-1:0]      idx;
    int unsigned           n;
    int unsigned           kind;
    bit                    first_phase;
    place_req_t            req;

    box_reg     = '{CFG_BOX_X, CFG_BOX_Y, CFG_BOX_Z};
    chk         = new();
    items_sent  = 0;
    next_gap    = 0;
    first_phase = 1'b1;
    sender_fast   = 1'b0;
    receiver_fast = 1'b0;
    rst_ni       = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    command_i    = '0;
    frac_x_i     = '0;
    frac_y_i     = '0;
    frac_z_i     = '0;
    read_index_i = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at reset settings
    rnd_frac = FRAC_W'($urandom());
    send_item(mk_req(CMD_READ, rnd_frac, ~rnd_frac, rnd_frac, 6'd0), 1'b0);
    send_item(mk_req(CMD_OFFER, FRAC_MID, FRAC_MID, FRAC_MID, 6'd0), 1'b0);
    // exactly one radius away: equal distance is allowed
    send_item(mk_req(CMD_OFFER, FRAC_AT_RADIUS, FRAC_MID, FRAC_MID, 6'd0), 1'b0);
    // one lsb short of the radius: rejected
    send_item(mk_req(CMD_OFFER, FRAC_MID, FRAC_INSIDE, FRAC_MID, 6'd0), 1'b0);
    send_item(mk_req(CMD_OFFER, 16'h0000, 16'h0000, 16'h0000, 6'd63), 1'b0);
    send_item(mk_req(CMD_OFFER, 16'hffff, 16'hffff, 16'hffff, 6'd0), 1'b0);
    send_item(mk_req(CMD_OFFER, FRAC_MID, FRAC_MID, FRAC_MID, 6'd0), 1'b0);
    send_item(mk_req(CMD_READ, 16'hffff, 16'h0000, 16'hffff, 6'd0), 1'b0);
    send_item(mk_req(CMD_READ, 16'h0000, 16'hffff, 16'h0000, 6'd3), 1'b0);
    send_item(mk_req(CMD_READ, 16'h0000, 16'h0000, 16'h0000, 6'd4), 1'b0);
    send_item(mk_req(CMD_READ, 16'h0000, 16'h0000, 16'h0000, 6'd63), 1'b0);
    send_item(mk_req(CMD_UNUSED, 16'hffff, 16'hffff, 16'hffff, 6'd63), 1'b0);
    send_item(mk_req(CMD_CLEAR, 16'hffff, 16'hffff, 16'hffff, 6'd63), 1'b0);
    send_item(mk_req(CMD_READ, 16'h0000, 16'h0000, 16'h0000, 6'd0), 1'b0);
    send_item(mk_req(CMD_OFFER, FRAC_W'($urandom()), FRAC_W'($urandom()),
                     FRAC_W'($urandom()), 6'd0), 1'b1);
    wait_idle();
    // a target of one: the second offer only gets scaled
    set_reg(CFG_TARGET, 16'd1);
    send_item(mk_req(CMD_CLEAR, 16'h0000, 16'h0000, 16'h0000, 6'd0), 1'b0);
    send_item(mk_req(CMD_OFFER, 16'h1234, 16'hfedc, 16'h8000, 6'd0), 1'b0);
    send_item(mk_req(CMD_OFFER, 16'h1234, 16'hfedc, 16'h8000, 6'd0), 1'b0);
    send_item(mk_req(CMD_READ, 16'h0000, 16'h0000, 16'h0000, 6'd0), 1'b1);

    // random phases, each with its own settings and pacing
    while (items_sent < TOTAL_ITEMS) begin
      wait_idle();
      if (first_phase || $urandom_range(0, 1)) begin
        case ($urandom_range(0, 9))
          0:       val = 16'd0;
          1:       val = 16'd1;
          2:       val = 16'd64;
          3:       val = 16'd127;
          default: val = CFG_DATA_W'($urandom_range(2, 64));
        endcase
        set_reg(CFG_TARGET, val);
      end
      if (first_phase || $urandom_range(0, 1)) begin
        case ($urandom_range(0, 9))
          0:       val = 16'd0;
          1:       val = 16'hffff;
          2:       val = RADIUS_RST;
          default: val = CFG_DATA_W'($urandom_range(1, 1536));
        endcase
        set_reg(CFG_RADIUS, val);
      end
      for (int k = 0; k < 3; k++) begin
        if (first_phase || $urandom_range(0, 1)) begin
          case ($urandom_range(0, 9))
            0:       val = 16'd0;
            1:       val = 16'hffff;
            2:       val = CFG_DATA_W'($urandom());
            default: val = CFG_DATA_W'($urandom_range(256, 8192));
          endcase
          set_reg(box_reg[k], val);
        end
      end
      if (first_phase) set_reg(CFG_SPARE, CFG_DATA_W'($urandom()));
      first_phase   = 1'b0;
      sender_fast   = ($urandom_range(0, 3) == 0);
      receiver_fast = ($urandom_range(0, 3) == 0);
      recent.delete();

      n = $urandom_range(40, 120);
      for (int i = 0; i < n; i++) begin
        kind = (i == 0) ? 95 : $urandom_range(0, 99);
        idx  = IDX_W'($urandom());
        if (kind < 68) begin
          cmd = CMD_OFFER;
          if (recent.size() != 0 && $urandom_range(0, 4) == 0) begin
            // nudge an earlier candidate to probe the distance boundary
            base = recent[$urandom_range(0, recent.size() - 1)];
            req = mk_req(cmd, base[47:32] + 16'($urandom_range(0, 128)) - 16'd64,
                         base[31:16] + 16'($urandom_range(0, 128)) - 16'd64,
                         base[15:0] + 16'($urandom_range(0, 128)) - 16'd64, idx);
          end else begin
            req = mk_req(cmd, FRAC_W'($urandom()), FRAC_W'($urandom()),
                         FRAC_W'($urandom()), idx);
          end
          base   = {req.frac_x, req.frac_y, req.frac_z};
          recent = {recent, base};
          if (recent.size() > 16) void'(recent.pop_front());
        end else if (kind < 88) begin
          if (chk.n_placed != 0 && $urandom_range(0, 4) != 0)
            idx = IDX_W'($urandom_range(0, chk.n_placed - 1));
          req = mk_req(CMD_READ, FRAC_W'($urandom()), FRAC_W'($urandom()),
                       FRAC_W'($urandom()), idx);
        end else if (kind < 92) begin
          req = mk_req(CMD_UNUSED, FRAC_W'($urandom()), FRAC_W'($urandom()),
                       FRAC_W'($urandom()), idx);
        end else begin
          req = mk_req(CMD_CLEAR, FRAC_W'($urandom()), FRAC_W'($urandom()),
                       FRAC_W'($urandom()), idx);
        end
        send_item(req, i == n - 1);
      end
    end

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (chk.errors == 0 && chk.expected_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
